>>> sv/nss_pkg.sv
`timescale 1ns / 1ps
package nss_pkg;

   localparam int VALUE_W           = 32;
   localparam int WINDOW_W          = 4;
   localparam int HEAP_CAPACITY_DEF = 16;
   localparam int CSR_DATA_W        = 32;
   localparam int CSR_ADDR_W        = 3;

   // register index, taken from paddr[2]
   localparam logic CSR_WINDOW_K = 1'b0;

   localparam logic [1:0] CMD_HOLD   = 2'd0;
   localparam logic [1:0] CMD_INSERT = 2'd1;
   localparam logic [1:0] CMD_POP    = 2'd2;

   typedef logic signed [VALUE_W-1:0] value_type;

   // what one cell shows its neighbors
   typedef struct packed {
      value_type value;
      logic      valid;
      logic      place;
   } nss_nbr_type;

   // broadcast to every cell
   typedef struct packed {
      logic [1:0] cmd;
      value_type  value;
   } nss_ctl_type;

endpackage

>>> sv/nss_cell.sv
`timescale 1ns / 1ps
module nss_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  nss_pkg::nss_ctl_type ctl,
   input  nss_pkg::nss_nbr_type left,
   input  nss_pkg::nss_nbr_type right,
   output nss_pkg::nss_nbr_type own
);
   import nss_pkg::*;

   value_type value_ff;
   value_type value_in;
   logic      valid_ff;
   logic      valid_in;
   logic      place;

   // new value goes here or further left; chain stays ascending
   assign place = !valid_ff || (ctl.value < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      unique case (ctl.cmd)
         CMD_INSERT: begin
            if (left.place) begin
               value_in = left.value;
            end else if (place) begin
               value_in = ctl.value;
            end
            valid_in = valid_ff | left.valid;
         end
         CMD_POP: begin
            value_in = right.value;
            valid_in = right.valid;
         end
         default: begin
            value_in = value_ff;
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign own.value = value_ff;
   assign own.valid = valid_ff;
   assign own.place = place;

endmodule

>>> sv/nearly_sorted_stream_sorter.sv
`timescale 1ns / 1ps
// An item is stored in the cell chain at its accept edge; a result it causes
// goes via the emit state into the output register, and a drain then gives
// one result per cycle while the output is not stalled. In steady state each
// item takes one insert and one pop; an item marked last pops every entry.
// Reset: synchronous, clears cell valid bits, count, state and window_k.
module nearly_sorted_stream_sorter #(
   parameter int HEAP_CAPACITY = nss_pkg::HEAP_CAPACITY_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  nss_pkg::value_type                req_in_value,
   input  logic                              req_in_last,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output nss_pkg::value_type                rsp_out_value,
   output logic                              rsp_out_last,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [nss_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [nss_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [nss_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);
   import nss_pkg::*;

   localparam int CNT_W = $clog2(HEAP_CAPACITY + 1);
   localparam int SUM_W = (CNT_W > WINDOW_W + 1) ? CNT_W : WINDOW_W + 1;

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_EMIT = 1'b1;

   logic                state_ff, state_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic                drain_ff, drain_in;
   logic [WINDOW_W-1:0] window_k_ff, window_k_in;
   logic                rsp_valid_ff, rsp_valid_in;
   value_type           rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;

   logic             accept;
   logic             pop;
   logic             csr_write;
   logic [SUM_W-1:0] k_plus;
   logic [SUM_W-1:0] window;
   logic [CNT_W-1:0] count_inc;
   logic [CNT_W-1:0] count_dec;

   nss_ctl_type ctl;
   nss_nbr_type nbr [HEAP_CAPACITY];
   nss_nbr_type edge_left;
   nss_nbr_type edge_right;

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      window_k_in = window_k_ff;
      if (csr_write && (csr_paddr[2] == CSR_WINDOW_K)) begin
         window_k_in = csr_pwdata[WINDOW_W-1:0];
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == CSR_WINDOW_K) begin
         csr_prdata = CSR_DATA_W'(window_k_ff);
      end
   end

   // window limited to capacity
   assign k_plus = SUM_W'(window_k_ff) + SUM_W'(1);
   assign window = (k_plus > SUM_W'(HEAP_CAPACITY)) ? SUM_W'(HEAP_CAPACITY) : k_plus;

   assign count_inc = count_ff + CNT_W'(1);
   assign count_dec = count_ff - CNT_W'(1);

   assign req_stall = (state_ff != STATE_IDLE);
   assign accept    = req_valid && !req_stall;
   assign pop       = (state_ff == STATE_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      ctl.cmd   = CMD_HOLD;
      ctl.value = req_in_value;
      if (accept) begin
         ctl.cmd = CMD_INSERT;
      end else if (pop) begin
         ctl.cmd = CMD_POP;
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         STATE_IDLE: begin
            if (accept) begin
               count_in = count_inc;
               drain_in = req_in_last;
               if (req_in_last || (SUM_W'(count_inc) >= window)) begin
                  state_in = STATE_EMIT;
               end
            end
         end
         STATE_EMIT: begin
            if (pop) begin
               count_in     = count_dec;
               rsp_valid_in = 1'b1;
               rsp_value_in = nbr[0].value;
               rsp_last_in  = drain_ff && (count_dec == '0);
               if (drain_ff ? (count_dec == '0) : (SUM_W'(count_dec) < window)) begin
                  state_in = STATE_IDLE;
               end
            end
         end
         default: begin
            state_in = STATE_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         drain_ff     <= 1'b0;
         window_k_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         drain_ff     <= drain_in;
         window_k_ff  <= window_k_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_value = rsp_value_ff;
   assign rsp_out_last  = rsp_last_ff;

   // cell chain: cell 0 holds the minimum
   assign edge_left.value  = '0;
   assign edge_left.valid  = 1'b1;
   assign edge_left.place  = 1'b0;
   assign edge_right.value = '0;
   assign edge_right.valid = 1'b0;
   assign edge_right.place = 1'b1;

   for (genvar i = 0; i < HEAP_CAPACITY; i++) begin : g_cell
      nss_nbr_type left_nbr;
      nss_nbr_type right_nbr;
      if (i == 0) begin : g_first
         assign left_nbr = edge_left;
      end else begin : g_inner_l
         assign left_nbr = nbr[i-1];
      end
      if (i == HEAP_CAPACITY - 1) begin : g_end
         assign right_nbr = edge_right;
      end else begin : g_inner_r
         assign right_nbr = nbr[i+1];
      end
      nss_cell u_cell (
         .clock (clock),
         .reset (reset),
         .ctl   (ctl),
         .left  (left_nbr),
         .right (right_nbr),
         .own   (nbr[i])
      );
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(HEAP_CAPACITY))
      else $error("entry count beyond capacity");

   assert property (@(posedge clock) disable iff (reset)
      nbr[0].valid == (count_ff != '0))
      else $error("head cell valid disagrees with count");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == STATE_EMIT) |-> (count_ff != '0))
      else $error("pop from empty chain");

   assert property (@(posedge clock) disable iff (reset)
      (nbr[0].valid && nbr[1].valid) |-> (nbr[0].value <= nbr[1].value))
      else $error("cell chain out of order");

   assert property (@(posedge clock) disable iff (reset)
      (pop && drain_ff && (count_ff == CNT_W'(1))) |=> (count_ff == '0) && rsp_last_ff)
      else $error("drain end not flagged");

endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import nss_pkg::*;

   localparam int STALL_LIMIT = 2000;
   localparam int SETTLE_CYCLES = 8;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   value_type             req_in_value = '0;
   logic                  req_in_last = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   value_type             rsp_out_value;
   logic                  rsp_out_last;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   typedef struct {
      value_type value;
      logic      last;
   } sorted_item_type;

   // Keeps the pending values in ascending order; pops come off the front.
   class sort_scoreboard;
      value_type           pending_q[$];
      sorted_item_type     due_q[$];
      logic [WINDOW_W-1:0] window_k;
      int                  capacity;
      int                  errors;

      function new(int cap);
         capacity = cap;
         window_k = '0;
         errors = 0;
      endfunction

      function void note_item(value_type value, logic last);
         int window;
         int pos;
         sorted_item_type r;
         window = int'(window_k) + 1;
         if (window > capacity) window = capacity;
         if (pending_q.size() < capacity) begin
            pos = 0;
            while (pos < pending_q.size() && pending_q[pos] <= value) pos++;
            pending_q.insert(pos, value);
         end
         if (last) begin
            while (pending_q.size() > 0) begin
               r.value = pending_q.pop_front();
               r.last = (pending_q.size() == 0);
               due_q.push_back(r);
            end
         end else begin
            while (pending_q.size() > 0 && pending_q.size() >= window) begin
               r.value = pending_q.pop_front();
               r.last = 1'b0;
               due_q.push_back(r);
            end
         end
      endfunction

      function void check_result(value_type value, logic last);
         sorted_item_type exp_r;
         if (due_q.size() == 0) begin
            $display("%0t: unexpected item, out_value %0d out_last %0b", $time, value, last);
            errors++;
         end else begin
            exp_r = due_q.pop_front();
            if (exp_r.value !== value) begin
               $display("%0t: out_value expected %0d, got %0d", $time, exp_r.value, value);
               errors++;
            end
            if (exp_r.last !== last) begin
               $display("%0t: out_last expected %0b, got %0b", $time, exp_r.last, last);
               errors++;
            end
         end
      endfunction
   endclass

   sort_scoreboard sb;
   int send_gap_pct = 0;
   int rsp_stall_pct = 0;
   int items_sent = 0;
   int quiet_cycles = 0;

   nearly_sorted_stream_sorter i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_in_value  (req_in_value),
      .req_in_last   (req_in_last),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value),
      .rsp_out_last  (rsp_out_last),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_result(rsp_out_value, rsp_out_last);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
         $display("testbench NOT OK");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_item(input value_type value, input logic last);
      req_valid <= 1'b1;
      req_in_value <= value;
      req_in_last <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_item(value, last);
      items_sent++;
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // Heap entries may sit inside the block with nothing due, so after the due
   // queue empties, wait out any pop still in flight.
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.due_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_window(input logic [WINDOW_W-1:0] k);
      logic [CSR_ADDR_W-1:0] addr;
      addr = '0;
      addr[2] = CSR_WINDOW_K;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= CSR_DATA_W'(k);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.window_k = k;
      // read back
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata[WINDOW_W-1:0] !== k) begin
         $display("%0t: window_k expected %0d, got %0d", $time, k, csr_prdata[WINDOW_W-1:0]);
         sb.errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [WINDOW_W-1:0] pick_window();
      int r;
      r = $urandom_range(0, 5);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return WINDOW_W'($urandom_range(0, 15));
   endfunction

   // Mostly nearly sorted streams; some pure noise, some with many equal
   // values, some displaced further than the window allows.
   task automatic random_stream();
      value_type vals[$];
      value_type v;
      value_type t;
      int mode;
      int n;
      int span;
      int disp;
      int j;
      int split;
      if ($urandom_range(0, 2) == 0) begin
         wait_idle();
         program_window(pick_window());
      end
      n = $urandom_range(1, 2 * (int'(sb.window_k) + 1) + 8);
      mode = $urandom_range(0, 9);
      span = ($urandom_range(0, 1) == 0) ? 1000 : (1 << $urandom_range(1, 28));
      v = value_type'($urandom);
      for (int i = 0; i < n; i++) begin
         if (mode == 0) begin
            vals.push_back(value_type'($urandom));
         end else if (mode == 1) begin
            vals.push_back(value_type'($urandom_range(0, 3)) - 2);
         end else begin
            vals.push_back(v);
            v = v + value_type'($urandom_range(0, span));
         end
      end
      disp = int'(sb.window_k) + ((mode == 2) ? 3 : 0);
      for (int i = 0; i < n; i++) begin
         j = i + $urandom_range(0, disp);
         if (j < n && $urandom_range(0, 1) == 1) begin
            t = vals[i];
            vals[i] = vals[j];
            vals[j] = t;
         end
      end
      split = ($urandom_range(0, 7) == 0) ? n / 2 : -1;
      for (int i = 0; i < n; i++) begin
         if (i == split && i > 0) begin
            wait_idle();
            program_window(pick_window());
         end
         send_item(vals[i], i == n - 1);
      end
   endtask

   initial begin
      sb = new(HEAP_CAPACITY_DEF);
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_gap_pct = 11;
      rsp_stall_pct = 73;

      // window of one: every item passes straight through
      program_window(4'd0);
      send_item(32'sh7FFF_FFFF, 1'b0);
      send_item(32'sh8000_0000, 1'b0);
      send_item(32'sh0000_0000, 1'b0);
      send_item(32'shFFFF_FFFF, 1'b1);
      wait_idle();
      // stream ends before the heap fills
      program_window(4'd3);
      send_item(32'sd5, 1'b0);
      send_item(-32'sd5, 1'b1);
      wait_idle();
      // equal values
      program_window(4'd2);
      send_item(32'sd9, 1'b0);
      send_item(32'sd9, 1'b0);
      send_item(32'sd9, 1'b0);
      send_item(-32'sd9, 1'b0);
      send_item(32'sd9, 1'b1);
      wait_idle();
      // window shrinks with entries held: one item then yields several
      program_window(4'd7);
      send_item(32'sd40, 1'b0);
      send_item(32'sd10, 1'b0);
      send_item(32'sd30, 1'b0);
      send_item(32'sd20, 1'b0);
      send_item(32'sd0, 1'b0);
      wait_idle();
      program_window(4'd1);
      send_item(32'sd25, 1'b0);
      send_item(32'sd50, 1'b1);
      wait_idle();
      program_window(4'd15);

      while (items_sent < 185) random_stream();
      wait_idle();
      send_gap_pct = 73;
      rsp_stall_pct = 11;
      while (items_sent < 350) random_stream();
      wait_idle();
      send_gap_pct = 0;
      rsp_stall_pct = 0;
      while (items_sent < 520) random_stream();
      wait_idle();

      if (sb.due_q.size() != 0) begin
         $display("%0t: %0d expected items never arrived", $time, sb.due_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("testbench OK");
      end else begin
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule
